>>> design/fsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsq_pkg;

  localparam int FP_W          = 32;
  localparam int MUL_LAT       = 3;
  localparam int SUB_LAT       = 4;
  localparam int DIV_BITS      = 27;
  localparam int DIV_PER_STG   = 3;
  localparam int DIV_STG       = DIV_BITS / DIV_PER_STG;
  localparam int DIV_LAT       = DIV_STG + 2;
  localparam int NEWTON_LAT    = 3 * MUL_LAT + SUB_LAT;
  localparam int TOTAL_LAT     = MUL_LAT + 2 * NEWTON_LAT + DIV_LAT;

  localparam logic [31:0] MAGIC_SEED      = 32'h5f3759df;
  localparam logic [31:0] CANON_NAN       = 32'h7fc00000;
  localparam logic [31:0] FP_HALF         = 32'h3f000000;
  localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] FP_ONE          = 32'h3f800000;

  // value = man * 2^(exp-23), man normalized with leading one at bit 23
  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [23:0]        man;
    logic               zero;
    logic               inf;
    logic               nan;
  } fsq_unp_t;

  function automatic logic [5:0] lzc28(input logic [27:0] v);
    logic [5:0] cnt;
    cnt = 6'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) cnt = 6'(27 - i);
    end
    return cnt;
  endfunction

  function automatic fsq_unp_t unpack(input logic [31:0] b);
    fsq_unp_t    u;
    logic [23:0] sub;
    logic [5:0]  lz;
    sub    = {1'b0, b[22:0]};
    lz     = lzc28({sub, 4'hf});
    u.sign = b[31];
    u.nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    u.zero = (b[30:0] == 31'd0);
    if (b[30:23] != 8'd0) begin
      u.man = {1'b1, b[22:0]};
      u.exp = $signed({4'b0, b[30:23]}) - 12'sd127;
    end else begin
      u.man = sub << lz;
      u.exp = -12'sd126 - $signed({6'b0, lz});
    end
    return u;
  endfunction

  // m: [25] leading one, [24:2] fraction, [1] guard, [0] sticky
  function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                             input logic [25:0] m);
    logic signed [11:0] be;
    logic signed [11:0] shw;
    logic [4:0]         sh;
    logic [51:0]        wide;
    logic [25:0]        kept;
    logic               lost;
    logic               up;
    logic [24:0]        sum;
    logic [8:0]         fld;
    logic [31:0]        res;
    be  = e + 12'sd127;
    shw = 12'sd1 - be;
    if (be >= 12'sd1) begin
      sh = 5'd0;
    end else if (be < -12'sd24) begin
      sh = 5'd26;
    end else begin
      sh = shw[4:0];
    end
    wide = {m, 26'b0} >> sh;
    kept = wide[51:26];
    lost = |wide[25:0];
    up   = kept[1] & (kept[0] | lost | kept[2]);
    sum  = {1'b0, kept[25:2]} + {24'b0, up};
    if (be >= 12'sd1) begin
      fld = be[8:0] + {8'b0, sum[24]};
    end else begin
      fld = {8'b0, sum[23]};
    end
    if (fld >= 9'd255) begin
      res = {s, 8'hff, 23'b0};
    end else begin
      res = {s, fld[7:0], sum[22:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/fast_sqrt_float_core.sv
`timescale 1ns / 1ps
`default_nettype none
// approximate single-precision square root by the classic inverse-root trick:
// x = v * 0.5, y = magic - (v >> 1), two newton steps y = y * (1.5 - x*y*y),
// then root = 1 / y, every operation rounded to nearest even with subnormals
// kept. a new item may be started every clock (busy stays low); its result
// shows on out_root_bits with out_valid high for exactly one cycle. the
// receiver cannot stall, so it must take every strobe. the chain of float
// units is the halving multiply, two newton steps of three multiplies and a
// subtract each, and the reciprocal (a radix-2 divider at three quotient bits
// per stage). any nan result comes out as the canonical quiet nan 0x7fc00000.
module fast_sqrt_float_core
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  output logic [31:0] out_root_bits
);

  // fully pipelined, never busy
  assign busy = 1'b0;

  logic [31:0] seed;
  logic [31:0] x_h,  y0_h,  y0_m1, y0_m3;
  logic [31:0] x_s2, y1_m1, y1_m3;
  logic [31:0] xy1, xyy1, d1, y1;
  logic [31:0] xy2, xyy2, d2, y2;
  logic        vx, vxy1, vxyy1, vd1, vy1, vxy2, vxyy2, vd2, vy2;

  // initial estimate, wraps modulo 2^32
  assign seed = MAGIC_SEED - {1'b0, in_value_bits[31:1]};

  fsq_fmul u_half (
    .clk, .rst_n, .in_valid(start), .in_a(in_value_bits), .in_b(FP_HALF),
    .out_valid(vx), .out_res(x_h)
  );

  // seed lines up with x
  fsq_delay #(.W(FP_W), .DEPTH(MUL_LAT)) u_dly_seed (
    .clk, .in_data(seed), .out_data(y0_h)
  );

  // first newton step
  fsq_fmul u_xy1 (
    .clk, .rst_n, .in_valid(vx), .in_a(x_h), .in_b(y0_h),
    .out_valid(vxy1), .out_res(xy1)
  );
  fsq_delay #(.W(FP_W), .DEPTH(MUL_LAT)) u_dly_y0a (
    .clk, .in_data(y0_h), .out_data(y0_m1)
  );
  fsq_fmul u_xyy1 (
    .clk, .rst_n, .in_valid(vxy1), .in_a(xy1), .in_b(y0_m1),
    .out_valid(vxyy1), .out_res(xyy1)
  );
  fsq_fsub u_sub1 (
    .clk, .rst_n, .in_valid(vxyy1), .in_a(FP_THREE_HALVES), .in_b(xyy1),
    .out_valid(vd1), .out_res(d1)
  );
  fsq_delay #(.W(FP_W), .DEPTH(MUL_LAT + SUB_LAT)) u_dly_y0b (
    .clk, .in_data(y0_m1), .out_data(y0_m3)
  );
  fsq_fmul u_y1 (
    .clk, .rst_n, .in_valid(vd1), .in_a(y0_m3), .in_b(d1),
    .out_valid(vy1), .out_res(y1)
  );

  // x held across the first step
  fsq_delay #(.W(FP_W), .DEPTH(NEWTON_LAT)) u_dly_x (
    .clk, .in_data(x_h), .out_data(x_s2)
  );

  // second newton step
  fsq_fmul u_xy2 (
    .clk, .rst_n, .in_valid(vy1), .in_a(x_s2), .in_b(y1),
    .out_valid(vxy2), .out_res(xy2)
  );
  fsq_delay #(.W(FP_W), .DEPTH(MUL_LAT)) u_dly_y1a (
    .clk, .in_data(y1), .out_data(y1_m1)
  );
  fsq_fmul u_xyy2 (
    .clk, .rst_n, .in_valid(vxy2), .in_a(xy2), .in_b(y1_m1),
    .out_valid(vxyy2), .out_res(xyy2)
  );
  fsq_fsub u_sub2 (
    .clk, .rst_n, .in_valid(vxyy2), .in_a(FP_THREE_HALVES), .in_b(xyy2),
    .out_valid(vd2), .out_res(d2)
  );
  fsq_delay #(.W(FP_W), .DEPTH(MUL_LAT + SUB_LAT)) u_dly_y1b (
    .clk, .in_data(y1_m1), .out_data(y1_m3)
  );
  fsq_fmul u_y2 (
    .clk, .rst_n, .in_valid(vd2), .in_a(y1_m3), .in_b(d2),
    .out_valid(vy2), .out_res(y2)
  );

  // root = 1 / y, registered at its output
  fsq_recip u_recip (
    .clk, .rst_n, .in_valid(vy2), .in_b(y2),
    .out_valid(out_valid), .out_res(out_root_bits)
  );

endmodule
`default_nettype wire

>>> design/fsq_delay.sv
`timescale 1ns / 1ps
`default_nettype none
module fsq_delay
  import fsq_pkg::*;
#(
  parameter int W     = FP_W,
  parameter int DEPTH = MUL_LAT
) (
  input  logic         clk,
  input  logic [W-1:0] in_data,
  output logic [W-1:0] out_data
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    tap_r[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign out_data = tap_r[DEPTH-1];

endmodule
`default_nettype wire

>>> design/fsq_fmul.sv
`timescale 1ns / 1ps
`default_nettype none
module fsq_fmul
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic        out_valid,
  output logic [31:0] out_res
);

  // stage 1: unpack, subnormals normalized
  fsq_unp_t ua_r, ub_r;
  logic     v1_r;
  // stage 2: significand product
  logic [47:0]        prod_r;
  logic signed [11:0] esum_r;
  logic               sgn_r, nan_r, inf_r, zero_r, v2_r;
  // stage 3: round
  logic [25:0]        m_nxt;
  logic signed [11:0] e_nxt;
  logic [31:0]        res_nxt;
  logic [31:0]        res_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    ua_r   <= unpack(in_a);
    ub_r   <= unpack(in_b);
    prod_r <= ua_r.man * ub_r.man;
    esum_r <= ua_r.exp + ub_r.exp;
    sgn_r  <= ua_r.sign ^ ub_r.sign;
    nan_r  <= ua_r.nan | ub_r.nan | (ua_r.inf & ub_r.zero) | (ua_r.zero & ub_r.inf);
    inf_r  <= ua_r.inf | ub_r.inf;
    zero_r <= ua_r.zero | ub_r.zero;
    res_r  <= res_nxt;
  end

  always_comb begin
    if (prod_r[47]) begin
      m_nxt = {prod_r[47:23], |prod_r[22:0]};
      e_nxt = esum_r + 12'sd1;
    end else begin
      m_nxt = {prod_r[46:22], |prod_r[21:0]};
      e_nxt = esum_r;
    end
    if (nan_r) begin
      res_nxt = CANON_NAN;
    end else if (inf_r) begin
      res_nxt = {sgn_r, 8'hff, 23'b0};
    end else if (zero_r) begin
      res_nxt = {sgn_r, 31'b0};
    end else begin
      res_nxt = round_pack(sgn_r, e_nxt, m_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

>>> design/fsq_fsub.sv
`timescale 1ns / 1ps
`default_nettype none
module fsq_fsub
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic        out_valid,
  output logic [31:0] out_res
);

  // computes a - b as a + (-b)
  fsq_unp_t    ua_nxt, ub_nxt;
  fsq_unp_t    ua_r, ub_r;
  logic        spec_nxt;
  logic [31:0] spec_bits_nxt;
  logic        spec1_r, spec2_r, spec3_r;
  logic [31:0] sbits1_r, sbits2_r, sbits3_r;

  logic               a_big;
  fsq_unp_t           big, sml;
  logic signed [11:0] d_nxt;
  logic [4:0]         dd;
  logic [55:0]        bw;
  logic [27:0]        opa_r, opb_r;
  logic signed [11:0] ebig2_r, ebig3_r;
  logic               sgn2_r, sgn3_r, subop_r;
  logic [27:0]        sum_r;

  logic [5:0]         lz;
  logic [27:0]        nrm;
  logic signed [11:0] e_nxt;
  logic [31:0]        res_nxt, res_r;
  logic               v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    ua_nxt      = unpack(in_a);
    ub_nxt      = unpack(in_b);
    ub_nxt.sign = ~ub_nxt.sign;
    spec_nxt    = 1'b1;
    if (ua_nxt.nan || ub_nxt.nan ||
        (ua_nxt.inf && ub_nxt.inf && (ua_nxt.sign != ub_nxt.sign))) begin
      spec_bits_nxt = CANON_NAN;
    end else if (ua_nxt.inf) begin
      spec_bits_nxt = {ua_nxt.sign, 8'hff, 23'b0};
    end else if (ub_nxt.inf) begin
      spec_bits_nxt = {ub_nxt.sign, 8'hff, 23'b0};
    end else if (ua_nxt.zero && ub_nxt.zero) begin
      spec_bits_nxt = {ua_nxt.sign & ub_nxt.sign, 31'b0};
    end else if (ub_nxt.zero) begin
      spec_bits_nxt = in_a;
    end else if (ua_nxt.zero) begin
      spec_bits_nxt = {ub_nxt.sign, in_b[30:0]};
    end else begin
      spec_nxt      = 1'b0;
      spec_bits_nxt = in_a;
    end
  end

  // align the smaller operand, guard/round/sticky kept in the low three bits
  always_comb begin
    a_big = ($signed(ua_r.exp) > $signed(ub_r.exp)) ||
            (($signed(ua_r.exp) == $signed(ub_r.exp)) && (ua_r.man >= ub_r.man));
    big   = a_big ? ua_r : ub_r;
    sml   = a_big ? ub_r : ua_r;
    d_nxt = $signed(big.exp) - $signed(sml.exp);
    if (d_nxt > 12'sd28) begin
      dd = 5'd28;
    end else begin
      dd = d_nxt[4:0];
    end
    bw = {1'b0, sml.man, 3'b0, 28'b0} >> dd;
  end

  always_comb begin
    lz    = lzc28(sum_r);
    nrm   = sum_r << lz;
    e_nxt = ebig3_r + 12'sd1 - $signed({6'b0, lz});
    if (spec3_r) begin
      res_nxt = sbits3_r;
    end else if (sum_r == 28'd0) begin
      res_nxt = 32'h0;
    end else begin
      res_nxt = round_pack(sgn3_r, e_nxt, {nrm[27:3], |nrm[2:0]});
    end
  end

  always_ff @(posedge clk) begin
    ua_r     <= ua_nxt;
    ub_r     <= ub_nxt;
    spec1_r  <= spec_nxt;
    sbits1_r <= spec_bits_nxt;
    opa_r    <= {1'b0, big.man, 3'b0};
    opb_r    <= {bw[55:29], bw[28] | (|bw[27:0])};
    ebig2_r  <= big.exp;
    sgn2_r   <= big.sign;
    subop_r  <= ua_r.sign ^ ub_r.sign;
    spec2_r  <= spec1_r;
    sbits2_r <= sbits1_r;
    sum_r    <= subop_r ? (opa_r - opb_r) : (opa_r + opb_r);
    ebig3_r  <= ebig2_r;
    sgn3_r   <= sgn2_r;
    spec3_r  <= spec2_r;
    sbits3_r <= sbits2_r;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

>>> design/fsq_recip.sv
`timescale 1ns / 1ps
`default_nettype none
module fsq_recip
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_b,
  output logic        out_valid,
  output logic [31:0] out_res
);

  fsq_unp_t    u_nxt;
  logic        spec_nxt;
  logic [31:0] sbits_nxt;

  logic [24:0]          rem_r   [0:DIV_STG];
  logic [DIV_BITS-1:0]  quo_r   [0:DIV_STG];
  logic [23:0]          man_r   [0:DIV_STG];
  logic signed [11:0]   exp_r   [0:DIV_STG];
  logic                 sgn_r   [0:DIV_STG];
  logic                 spec_r  [0:DIV_STG];
  logic [31:0]          sbits_r [0:DIV_STG];
  logic                 v_r     [0:DIV_STG];

  logic [DIV_BITS-1:0] q_fin;
  logic                sticky;
  logic [25:0]         m_nxt;
  logic signed [11:0]  e_nxt;
  logic [31:0]         res_nxt, res_r;
  logic                vo_r;

  always_comb begin
    u_nxt    = unpack(in_b);
    spec_nxt = 1'b1;
    if (u_nxt.nan) begin
      sbits_nxt = CANON_NAN;
    end else if (u_nxt.inf) begin
      sbits_nxt = {u_nxt.sign, 31'b0};
    end else if (u_nxt.zero) begin
      sbits_nxt = {u_nxt.sign, 8'hff, 23'b0};
    end else begin
      spec_nxt  = 1'b0;
      sbits_nxt = FP_ONE;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]   <= 25'h0800000;
    quo_r[0]   <= '0;
    man_r[0]   <= u_nxt.man;
    exp_r[0]   <= u_nxt.exp;
    sgn_r[0]   <= u_nxt.sign;
    spec_r[0]  <= spec_nxt;
    sbits_r[0] <= sbits_nxt;
  end

  // restoring division of 1.0 by the significand, a few quotient bits per stage
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    logic [24:0]         r_nxt;
    logic [DIV_BITS-1:0] q_nxt;

    always_comb begin
      r_nxt = rem_r[k];
      q_nxt = quo_r[k];
      for (int j = 0; j < DIV_PER_STG; j++) begin
        if (r_nxt >= {1'b0, man_r[k]}) begin
          r_nxt = r_nxt - {1'b0, man_r[k]};
          q_nxt = {q_nxt[DIV_BITS-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[DIV_BITS-2:0], 1'b0};
        end
        r_nxt = r_nxt << 1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]   <= r_nxt;
      quo_r[k+1]   <= q_nxt;
      man_r[k+1]   <= man_r[k];
      exp_r[k+1]   <= exp_r[k];
      sgn_r[k+1]   <= sgn_r[k];
      spec_r[k+1]  <= spec_r[k];
      sbits_r[k+1] <= sbits_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_comb begin
    q_fin  = quo_r[DIV_STG];
    sticky = (rem_r[DIV_STG] != 25'd0);
    if (q_fin[26]) begin
      m_nxt = {q_fin[26:2], |q_fin[1:0] | sticky};
      e_nxt = 12'sd0 - exp_r[DIV_STG];
    end else begin
      m_nxt = {q_fin[25:1], q_fin[0] | sticky};
      e_nxt = -12'sd1 - exp_r[DIV_STG];
    end
    if (spec_r[DIV_STG]) begin
      res_nxt = sbits_r[DIV_STG];
    end else begin
      res_nxt = round_pack(sgn_r[DIV_STG], e_nxt, m_nxt);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      vo_r   <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      vo_r   <= v_r[DIV_STG];
    end
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

>>> design/fsq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fsq_checker
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        out_valid,
  input  logic [31:0] out_root_bits
);

  logic acc;
  assign acc = start && !busy && rst_n;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##TOTAL_LAT out_valid)
    else $error("item lost in pipeline");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, TOTAL_LAT))
    else $error("result without item");

  a_canon_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_bits[30:23] == 8'hff) && (out_root_bits[22:0] != 23'd0))
      |-> (out_root_bits == CANON_NAN))
    else $error("non-canonical nan");

endmodule

bind fast_sqrt_float_core fsq_checker u_fsq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_root_bits(out_root_bits)
);
`default_nettype wire
